// File: hw/rtl/catmull_rom_track_point_eval_core_defines.svh
// assertion macros shared by the rtl
`ifndef CATMULL_ROM_TRACK_POINT_EVAL_CORE_DEFINES_SVH
`define CATMULL_ROM_TRACK_POINT_EVAL_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// checked outside reset
`define CRTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define CRTP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CRTP_ASSERT(lbl, prop, msg)
`define CRTP_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: hw/rtl/crtp_pkg.sv
`default_nettype none
package crtp_pkg;

  // table geometry
  localparam int MAX_POINTS = 256;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int NUM_TAPS   = 4;

  // path parameter, 1.0 is 1 << T_FRAC_BITS
  localparam int T_FRAC_BITS = 16;
  localparam int T_W         = T_FRAC_BITS + 1;
  localparam int SCALED_W    = T_W + CNT_W;

  // coordinates and intermediate widths of the cubic
  localparam int COORD_W = 32;
  localparam int A_W     = COORD_W + 1;
  localparam int B_W     = COORD_W + 4;
  localparam int CF_W    = COORD_W + 3;
  localparam int H1_W    = COORD_W + 5;
  localparam int H2_W    = COORD_W + 6;
  localparam int H3_W    = COORD_W + 7;
  localparam int M1_W    = CF_W + T_W + 1;
  localparam int M2_W    = H1_W + T_W + 1;
  localparam int M3_W    = H2_W + T_W + 1;

  // stream widths
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 96;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CNT_W;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSED_LOOP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 1'd1;

  // item kinds
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // x in the lowest bits
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } point_t;

  // load enables of the cubic stages
  typedef struct packed {
    logic s5;
    logic s6;
    logic s7;
    logic s8;
    logic s9;
  } crtp_en_t;

endpackage
`default_nettype wire

// File: hw/rtl/crtp_axis.sv
`default_nettype none
module crtp_axis
  import crtp_pkg::*;
(
  input  logic           clk_i,
  input  crtp_en_t       en_i,
  input  coord_t         p0_i,
  input  coord_t         p1_i,
  input  coord_t         p2_i,
  input  coord_t         p3_i,
  input  logic [T_W-1:0] frac_i,
  output coord_t         res_o
);

  logic signed [A_W-1:0]  a_d, a5_q, a6_q, a7_q;
  logic signed [B_W-1:0]  b_d, b5_q, b6_q;
  logic signed [CF_W-1:0] c_d, c5_q, dp;
  coord_t                 p1_5_q, p1_6_q, p1_7_q, p1_8_q;
  logic [T_W-1:0]         f5_q, f6_q, f7_q;
  logic signed [T_W:0]    f5s, f6s, f7s;
  logic signed [M1_W-1:0] m1_d, m1_q;
  logic signed [H1_W-1:0] h1;
  logic signed [M2_W-1:0] m2_d, m2_q;
  logic signed [H2_W-1:0] h2;
  logic signed [M3_W-1:0] m3_d, m3_q;
  logic signed [H3_W-1:0] h3, r;
  coord_t                 sat_d, res_q;

  // coefficients of the cubic
  always_comb begin
    a_d = A_W'(p2_i) - A_W'(p0_i);
    b_d = (B_W'(p0_i) <<< 1) - (B_W'(p1_i) <<< 2) - B_W'(p1_i)
        + (B_W'(p2_i) <<< 2) - B_W'(p3_i);
    dp  = CF_W'(p1_i) - CF_W'(p2_i);
    c_d = (dp <<< 1) + dp + CF_W'(p3_i) - CF_W'(p0_i);
  end

  // fraction as a non-negative signed operand
  assign f5s = {1'b0, f5_q};
  assign f6s = {1'b0, f6_q};
  assign f7s = {1'b0, f7_q};

  // horner steps, one multiply per stage
  always_comb begin
    m1_d = M1_W'(c5_q) * M1_W'(f5s);
    h1   = H1_W'(m1_q >>> T_FRAC_BITS) + H1_W'(b6_q);
    m2_d = M2_W'(h1) * M2_W'(f6s);
    h2   = H2_W'(m2_q >>> T_FRAC_BITS) + H2_W'(a7_q);
    m3_d = M3_W'(h2) * M3_W'(f7s);
  end

  // final add, halve and saturate
  always_comb begin
    h3 = H3_W'(m3_q >>> T_FRAC_BITS) + (H3_W'(p1_8_q) <<< 1);
    r  = h3 >>> 1;
    if (r > H3_W'(COORD_MAX)) begin
      sat_d = COORD_MAX;
    end else if (r < H3_W'(COORD_MIN)) begin
      sat_d = COORD_MIN;
    end else begin
      sat_d = COORD_W'(r);
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      a5_q   <= a_d;
      b5_q   <= b_d;
      c5_q   <= c_d;
      p1_5_q <= p1_i;
      f5_q   <= frac_i;
    end
    if (en_i.s6) begin
      m1_q   <= m1_d;
      a6_q   <= a5_q;
      b6_q   <= b5_q;
      p1_6_q <= p1_5_q;
      f6_q   <= f5_q;
    end
    if (en_i.s7) begin
      m2_q   <= m2_d;
      a7_q   <= a6_q;
      p1_7_q <= p1_6_q;
      f7_q   <= f6_q;
    end
    if (en_i.s8) begin
      m3_q   <= m3_d;
      p1_8_q <= p1_7_q;
    end
    if (en_i.s9) begin
      res_q <= sat_d;
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

// File: hw/rtl/catmull_rom_track_point_eval_core.sv
`default_nettype none
// Uniform Catmull-Rom evaluator over a table of up to 256 control points. A transaction with
// tuser 0 loads one point (no result); tuser 1 evaluates the path at t and returns one result,
// or zero with tuser set when fewer than two points are in use. The pipeline has nine register
// stages, and one transaction is taken every cycle when the output side keeps up. The point
// table is held in four copies, one per neighbor fetched, so all four taps are read together;
// a load is seen by an evaluate that directly follows it. Backpressure stalls only the stages
// that are full.
`include "catmull_rom_track_point_eval_core_defines.svh"
module catmull_rom_track_point_eval_core
  import crtp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration writes
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // point_index[7:0], pos_x[39:8], pos_y[71:40], pos_z[103:72], t_position[120:104], zeros
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // mode
  input  logic                   s_axis_tuser,
  // output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // too_few_points
  output logic                   m_axis_tuser
);

  localparam int NUM_STAGES = 9;
  localparam int IW         = CNT_W + 1;
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC_BITS;

  // configuration registers
  logic             closed_q;
  logic [CNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_q <= 1'b0;
      count_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CLOSED_LOOP: closed_q <= cfg_data_i[0];
        REG_POINT_COUNT: count_q  <= cfg_data_i;
      endcase
    end
  end

  // points in use and segment count
  logic [CNT_W-1:0] n_cnt, segs;
  assign n_cnt = (count_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_q;
  assign segs  = closed_q ? n_cnt : n_cnt - CNT_W'(1);

  // stage valids and ready chain
  logic [NUM_STAGES:1] vld_q, vin, rdy;
  logic mode1_q, mode2_q, mode3_q, mode4_q;

  always_comb begin
    vin[1] = s_axis_tvalid;
    for (int k = 2; k <= NUM_STAGES; k++) begin
      vin[k] = vld_q[k-1];
    end
    vin[5] = vld_q[4] & (mode4_q == MODE_EVAL);
  end

  always_comb begin
    rdy[NUM_STAGES] = !vld_q[NUM_STAGES] | m_axis_tready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      rdy[k] = !vld_q[k] | rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= NUM_STAGES; k++) begin
        if (rdy[k]) vld_q[k] <= vin[k];
      end
    end
  end

  logic [NUM_STAGES:1] en;
  assign en = rdy & vin;

  // stage 1: input register
  logic [IDX_W-1:0] idx1_q, idx2_q, idx3_q;
  point_t           pos1_q, pos2_q, pos3_q;
  logic [T_W-1:0]   t1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      mode1_q <= s_axis_tuser;
      idx1_q  <= s_axis_tdata[IDX_W-1:0];
      pos1_q  <= point_t'(s_axis_tdata[IDX_W +: 3*COORD_W]);
      t1_q    <= s_axis_tdata[IDX_W + 3*COORD_W +: T_W];
    end
  end

  // stage 2: scale t by the segment count
  logic [T_W-1:0]      t_clip;
  logic [SCALED_W-1:0] scaled_d, scaled2_q;
  logic                few2_q, few3_q, few4_q;
  logic [NUM_STAGES:5] few_q;

  assign t_clip   = (t1_q > T_ONE) ? T_ONE : t1_q;
  assign scaled_d = SCALED_W'(t_clip) * SCALED_W'(segs);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      mode2_q   <= mode1_q;
      idx2_q    <= idx1_q;
      pos2_q    <= pos1_q;
      scaled2_q <= scaled_d;
      few2_q    <= (n_cnt < CNT_W'(2));
    end
  end

  // stage 3: segment, fraction and neighbor indexes
  logic [IW-1:0]    seg_w, n_w, segs_w, s_w, w0, w2, w3;
  logic [T_W-1:0]   frac_d, frac3_q, frac4_q;
  logic [IDX_W-1:0] tap_d [NUM_TAPS];
  logic [IDX_W-1:0] tap_q [NUM_TAPS];

  always_comb begin
    seg_w  = IW'(scaled2_q[T_FRAC_BITS +: CNT_W]);
    n_w    = IW'(n_cnt);
    segs_w = IW'(segs);
    frac_d = {1'b0, scaled2_q[T_FRAC_BITS-1:0]};
    if (closed_q) begin
      // wrap around the loop
      s_w = (seg_w == n_w) ? '0 : seg_w;
      w0  = (s_w == '0) ? n_w - IW'(1) : s_w - IW'(1);
      w2  = (s_w + IW'(1) == n_w) ? '0 : s_w + IW'(1);
      w3  = (s_w + IW'(2) >= n_w) ? s_w + IW'(2) - n_w : s_w + IW'(2);
    end else begin
      // clamp at both ends, t of one ends on the last segment
      s_w = seg_w;
      if (seg_w >= segs_w) begin
        s_w    = segs_w - IW'(1);
        frac_d = T_ONE;
      end
      w0 = (s_w == '0) ? '0 : s_w - IW'(1);
      w2 = (s_w + IW'(1) < n_w) ? s_w + IW'(1) : n_w - IW'(1);
      w3 = (s_w + IW'(2) < n_w) ? s_w + IW'(2) : n_w - IW'(1);
    end
    tap_d[0] = w0[IDX_W-1:0];
    tap_d[1] = s_w[IDX_W-1:0];
    tap_d[2] = w2[IDX_W-1:0];
    tap_d[3] = w3[IDX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      mode3_q <= mode2_q;
      idx3_q  <= idx2_q;
      pos3_q  <= pos2_q;
      frac3_q <= frac_d;
      few3_q  <= few2_q;
      tap_q   <= tap_d;
    end
  end

  // stage 4: point table, one copy per tap
  point_t pts_mem_q [NUM_TAPS][MAX_POINTS];
  point_t rd_q      [NUM_TAPS];
  logic   mem_wr;

  assign mem_wr = en[4] & (mode3_q == MODE_LOAD);

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NUM_TAPS; b++) begin
      if (mem_wr) pts_mem_q[b][idx3_q] <= pos3_q;
      if (en[4])  rd_q[b] <= pts_mem_q[b][tap_q[b]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      mode4_q <= mode3_q;
      frac4_q <= frac3_q;
      few4_q  <= few3_q;
    end
  end

  // stages 5 to 9: the cubic per axis
  crtp_en_t ax_en;
  coord_t   res_x, res_y, res_z;

  assign ax_en.s5 = en[5];
  assign ax_en.s6 = en[6];
  assign ax_en.s7 = en[7];
  assign ax_en.s8 = en[8];
  assign ax_en.s9 = en[9];

  crtp_axis u_axis_x (
    .clk_i  (clk_i),
    .en_i   (ax_en),
    .p0_i   (rd_q[0].x),
    .p1_i   (rd_q[1].x),
    .p2_i   (rd_q[2].x),
    .p3_i   (rd_q[3].x),
    .frac_i (frac4_q),
    .res_o  (res_x)
  );

  crtp_axis u_axis_y (
    .clk_i  (clk_i),
    .en_i   (ax_en),
    .p0_i   (rd_q[0].y),
    .p1_i   (rd_q[1].y),
    .p2_i   (rd_q[2].y),
    .p3_i   (rd_q[3].y),
    .frac_i (frac4_q),
    .res_o  (res_y)
  );

  crtp_axis u_axis_z (
    .clk_i  (clk_i),
    .en_i   (ax_en),
    .p0_i   (rd_q[0].z),
    .p1_i   (rd_q[1].z),
    .p2_i   (rd_q[2].z),
    .p3_i   (rd_q[3].z),
    .frac_i (frac4_q),
    .res_o  (res_z)
  );

  // too-few flag follows the cubic stages
  always_ff @(posedge clk_i) begin
    if (en[5]) few_q[5] <= few4_q;
    for (int k = 6; k <= NUM_STAGES; k++) begin
      if (en[k]) few_q[k] <= few_q[k-1];
    end
  end

  // output side
  assign s_axis_tready = rdy[1];
  assign m_axis_tvalid = vld_q[NUM_STAGES];
  assign m_axis_tuser  = few_q[NUM_STAGES];
  assign m_axis_tdata  = few_q[NUM_STAGES] ? '0 : {res_z, res_y, res_x};

  // checks
  `CRTP_ASSERT_RST(a_rst_no_valid, !rst_ni |-> !m_axis_tvalid, "result valid during reset")
  `CRTP_ASSERT(a_stall_only_full, !s_axis_tready |-> (&vld_q), "input stalled with a free stage")
  `CRTP_ASSERT(a_few_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0, "flagged result not zero")
  `CRTP_ASSERT(a_load_no_result, vld_q[4] && (mode4_q == MODE_LOAD) && rdy[5] |=> !vld_q[5], "load made a result")

endmodule
`default_nettype wire
